### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mrqa_pkg.sv
// ---------------------------------------------------------------------------
// mrqa_pkg
// Types and constants shared by the quota admission block.
// ---------------------------------------------------------------------------
package mrqa_pkg;

  localparam int FIELD_W     = 64;  // width of amount, limit and usage fields
  localparam int SCOPE_W     = 4;
  localparam int OP_W        = 2;
  localparam int NRES        = 4;   // cost, latency, tokens, tool calls
  localparam int DEF_SCOPES  = 16;
  localparam int DEF_CNT_W   = 64;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE   = 2'd0,
    OP_RELEASE   = 2'd1,
    OP_SET_QUOTA = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_COST    = 3'd1,
    CAUSE_LATENCY = 3'd2,
    CAUSE_TOKENS  = 3'd3,
    CAUSE_TOOLS   = 3'd4
  } cause_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SCOPE_W-1:0] scope_index;
    logic [FIELD_W-1:0] cost_amount;
    logic [FIELD_W-1:0] latency_amount;
    logic [FIELD_W-1:0] token_amount;
    logic [FIELD_W-1:0] tool_call_amount;
    logic [FIELD_W-1:0] cost_limit;
    logic [FIELD_W-1:0] latency_limit;
    logic [FIELD_W-1:0] token_limit;
    logic [FIELD_W-1:0] tool_call_limit;
  } req_t;

  typedef struct packed {
    logic               granted;
    cause_t             refusal_cause;
    logic [FIELD_W-1:0] cost_after;
    logic [FIELD_W-1:0] latency_after;
    logic [FIELD_W-1:0] tokens_after;
    logic [FIELD_W-1:0] tool_calls_after;
  } rsp_t;

  // Table write strobes from the evaluator to the store.
  typedef struct packed {
    logic used_we;
    logic max_we;
  } wr_ctl_t;

endpackage

### rtl/core/mrqa_if.sv
// ---------------------------------------------------------------------------
// mrqa channel interfaces
// Valid/ready channels for request and response words.
// ---------------------------------------------------------------------------
interface mrqa_in_if import mrqa_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrqa_out_if import mrqa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/multi_resource_quota_admission.sv
// An accepted word is held in the input register, then in the response register.
// Throughput: one request per cycle unless the output stalls; the per-scope table
//   read, four compare/add/subtract lanes and table write close when it fires.
// Back pressure: the input register takes one more word after the output stalls.
// Reset: synchronous rst_n clears both valid flags and all usage and limit
//   entries in the same cycle; no clearing sweep follows.
// ---------------------------------------------------------------------------
// multi_resource_quota_admission
// Per-scope multi-resource quota admission: reserve, release, set limits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_resource_quota_admission import mrqa_pkg::*; #(
  parameter int SCOPES        = DEF_SCOPES,
  parameter int COUNTER_WIDTH = DEF_CNT_W
) (
  input  logic        clk,
  input  logic        rst_n,
  mrqa_in_if.sink     in_ch,
  mrqa_out_if.source  out_ch
);

  localparam int IDX_W = (SCOPES > 1) ? $clog2(SCOPES) : 1;

  // Input word register.
  req_t  req_r;
  logic  in_valid_r, in_valid_nxt;
  // Response word register.
  rsp_t  rsp_r, rsp_nxt;
  logic  out_valid_r, out_valid_nxt;

  logic  advance;   // response register free or being drained this cycle
  logic  fire;      // held request is evaluated and committed this edge
  logic  in_accept;

  logic [IDX_W+SCOPE_W-1:0]           idx_ext;
  logic [IDX_W-1:0]                   idx;
  wr_ctl_t                            wr;
  logic [NRES-1:0][COUNTER_WIDTH-1:0] rd_used, rd_max, new_used, new_max;

  // ----- handshake -----
  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = rsp_r;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      in_valid_nxt  = 1'b0;
      out_valid_nxt = in_valid_r;
    end
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_ch.data;
    end
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

  // ----- scope table index (zero-extend, then trim to table depth) -----
  assign idx_ext = {{IDX_W{1'b0}}, req_r.scope_index};
  assign idx     = idx_ext[IDX_W-1:0];

  // Table read is combinational from flops and the write lands at the
  // same edge as the response, so back-to-back words on one scope see
  // the updated counters with no bypass.
  mrqa_store #(
    .SCOPES        (SCOPES),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     (idx),
    .wr      (wr),
    .wr_used (new_used),
    .wr_max  (new_max),
    .rd_used (rd_used),
    .rd_max  (rd_max)
  );

  mrqa_eval #(
    .SCOPES        (SCOPES),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_eval (
    .fire     (fire),
    .req      (req_r),
    .used     (rd_used),
    .lim      (rd_max),
    .wr       (wr),
    .new_used (new_used),
    .new_max  (new_max),
    .rsp      (rsp_nxt)
  );

  // ----- assertions -----
  `CHK_ASSERT(a_deny_not_granted,
    out_valid_r && (rsp_r.refusal_cause != CAUSE_NONE) |-> !rsp_r.granted,
    "denied reserve reported as granted")
  `CHK_ASSERT(a_fire_loads_out,
    fire |=> out_valid_r,
    "evaluated word did not reach the response register")
  `CHK_ASSERT(a_no_write_when_idle,
    !fire |-> !wr.used_we && !wr.max_we,
    "table written without a word being committed")
  `CHK_ASSERT_ALWAYS(a_reset_empty,
    !rst_n |=> !out_valid_r && !in_valid_r,
    "word registers not empty after reset")

endmodule

### rtl/core/mrqa_store.sv
// ---------------------------------------------------------------------------
// mrqa_store
// Per-scope usage counters and limits, one read/write index per cycle.
// ---------------------------------------------------------------------------
module mrqa_store import mrqa_pkg::*; #(
  parameter int SCOPES        = DEF_SCOPES,
  parameter int COUNTER_WIDTH = DEF_CNT_W,
  localparam int IDX_W        = (SCOPES > 1) ? $clog2(SCOPES) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [IDX_W-1:0]                    idx,
  input  wr_ctl_t                             wr,
  input  logic [NRES-1:0][COUNTER_WIDTH-1:0]  wr_used,
  input  logic [NRES-1:0][COUNTER_WIDTH-1:0]  wr_max,
  output logic [NRES-1:0][COUNTER_WIDTH-1:0]  rd_used,
  output logic [NRES-1:0][COUNTER_WIDTH-1:0]  rd_max
);

  logic [NRES-1:0][COUNTER_WIDTH-1:0] used_r [SCOPES];
  logic [NRES-1:0][COUNTER_WIDTH-1:0] max_r  [SCOPES];

  // Out-of-range index reads are masked off downstream.
  assign rd_used = used_r[idx];
  assign rd_max  = max_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SCOPES; s++) begin
        used_r[s] <= '0;
        max_r[s]  <= '0;
      end
    end else begin
      if (wr.used_we) begin
        used_r[idx] <= wr_used;
      end
      if (wr.max_we) begin
        max_r[idx] <= wr_max;
      end
    end
  end

endmodule

### rtl/core/mrqa_eval.sv
// ---------------------------------------------------------------------------
// mrqa_eval
// Limit checks, counter updates and response word for one request.
// ---------------------------------------------------------------------------
module mrqa_eval import mrqa_pkg::*; #(
  parameter int SCOPES        = DEF_SCOPES,
  parameter int COUNTER_WIDTH = DEF_CNT_W
) (
  input  logic                                fire,
  input  req_t                                req,
  input  logic [NRES-1:0][COUNTER_WIDTH-1:0]  used,
  input  logic [NRES-1:0][COUNTER_WIDTH-1:0]  lim,
  output wr_ctl_t                             wr,
  output logic [NRES-1:0][COUNTER_WIDTH-1:0]  new_used,
  output logic [NRES-1:0][COUNTER_WIDTH-1:0]  new_max,
  output rsp_t                                rsp
);

  localparam int CMP_W = SCOPE_W + ((SCOPES > 1) ? $clog2(SCOPES) : 1) + 1;

  logic                               in_range;
  logic [NRES-1:0][COUNTER_WIDTH-1:0] amt;
  logic [NRES-1:0][COUNTER_WIDTH-1:0] sum;
  logic [NRES-1:0][COUNTER_WIDTH-1:0] dif;
  logic [NRES-1:0][COUNTER_WIDTH-1:0] after;
  logic [NRES-1:0]                    over;
  cause_t                             cause;

  assign in_range = CMP_W'(req.scope_index) < CMP_W'(SCOPES);

  assign amt[0] = req.cost_amount[COUNTER_WIDTH-1:0];
  assign amt[1] = req.latency_amount[COUNTER_WIDTH-1:0];
  assign amt[2] = req.token_amount[COUNTER_WIDTH-1:0];
  assign amt[3] = req.tool_call_amount[COUNTER_WIDTH-1:0];

  assign new_max[0] = req.cost_limit[COUNTER_WIDTH-1:0];
  assign new_max[1] = req.latency_limit[COUNTER_WIDTH-1:0];
  assign new_max[2] = req.token_limit[COUNTER_WIDTH-1:0];
  assign new_max[3] = req.tool_call_limit[COUNTER_WIDTH-1:0];

  // Per-resource check; lim - amt only matters once amt <= lim.
  always_comb begin
    for (int r = 0; r < NRES; r++) begin
      sum[r]  = used[r] + amt[r];
      dif[r]  = (amt[r] > used[r]) ? '0 : used[r] - amt[r];
      over[r] = (lim[r] != '0) &&
                ((amt[r] > lim[r]) || (used[r] > lim[r] - amt[r]));
    end
  end

  // First failing resource in cost, latency, tokens, tool-call order.
  always_comb begin
    if (over[0])      cause = CAUSE_COST;
    else if (over[1]) cause = CAUSE_LATENCY;
    else if (over[2]) cause = CAUSE_TOKENS;
    else if (over[3]) cause = CAUSE_TOOLS;
    else              cause = CAUSE_NONE;
  end

  always_comb begin
    after       = used;
    new_used    = used;
    wr          = '0;
    rsp.granted = 1'b0;
    rsp.refusal_cause = CAUSE_NONE;
    case (req.operation)
      OP_RESERVE: begin
        after             = sum;
        new_used          = sum;
        rsp.refusal_cause = cause;
        rsp.granted       = (cause == CAUSE_NONE);
        wr.used_we        = (cause == CAUSE_NONE);
      end
      OP_RELEASE: begin
        after       = dif;
        new_used    = dif;
        rsp.granted = 1'b1;
        wr.used_we  = 1'b1;
      end
      OP_SET_QUOTA: begin
        rsp.granted = 1'b1;
        wr.max_we   = 1'b1;
      end
      default: begin
        // unused opcode: report usage, change nothing
      end
    endcase

    if (!in_range) begin
      after             = '0;
      wr                = '0;
      rsp.granted       = 1'b0;
      rsp.refusal_cause = CAUSE_NONE;
    end
    if (!fire) begin
      wr = '0;
    end

    rsp.cost_after       = FIELD_W'(after[0]);
    rsp.latency_after    = FIELD_W'(after[1]);
    rsp.tokens_after     = FIELD_W'(after[2]);
    rsp.tool_calls_after = FIELD_W'(after[3]);
  end

endmodule
